[design/fhc_pkg.sv]
// ----------------------------------------------------------------------------
// fhc_pkg: shared types, codes and tables for the frame header checker
// Status codes, header field codes, parse phases and the CRC-8 step.
// ----------------------------------------------------------------------------
package fhc_pkg;

  localparam int unsigned StatusW = 3;
  localparam int unsigned SizeW   = 17;
  localparam int unsigned RateW   = 20;

  typedef logic [StatusW-1:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_SYNC  = 3'd1;
  localparam status_t ST_BAD_NUM   = 3'd2;
  localparam status_t ST_BAD_RATE  = 3'd3;
  localparam status_t ST_CRC_ERR   = 3'd4;
  localparam status_t ST_TRUNCATED = 3'd5;

  // Block-size codes that pull in an extension field
  localparam logic [3:0] SIZE_EXT8  = 4'h6;
  localparam logic [3:0] SIZE_EXT16 = 4'h7;

  // Sample-rate codes with special handling
  localparam logic [3:0] RATE_STREAM = 4'h0;
  localparam logic [3:0] RATE_TABLE_LAST = 4'hB;
  localparam logic [3:0] RATE_KHZ    = 4'hC;
  localparam logic [3:0] RATE_HZ     = 4'hD;
  localparam logic [3:0] RATE_DAHZ   = 4'hE;
  localparam logic [3:0] RATE_BAD    = 4'hF;

  localparam logic [7:0] SYNC_BYTE0  = 8'hFF;
  localparam logic [7:0] SYNC1_MASK  = 8'hFC;
  localparam logic [7:0] SYNC1_VALUE = 8'hF8;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  localparam logic [9:0]  KHZ_SCALE  = 10'd1000;
  localparam logic [RateW-1:0] DAHZ_SCALE = 20'd10;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_SYNC1 = 10'b00_0000_0010,
    PH_SYNC2 = 10'b00_0000_0100,
    PH_CODES = 10'b00_0000_1000,
    PH_CHAN  = 10'b00_0001_0000,
    PH_NUM0  = 10'b00_0010_0000,
    PH_NUMC  = 10'b00_0100_0000,
    PH_BSEXT = 10'b00_1000_0000,
    PH_SREXT = 10'b01_0000_0000,
    PH_CRC   = 10'b10_0000_0000
  } phase_t;

  // One finished header as it leaves the parser
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [SizeW-1:0] frame_samples;
    logic [RateW-1:0] frame_rate;
  } result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [SizeW-1:0] size_lookup(input logic [3:0] code);
    logic [SizeW-1:0] v;
    case (code)
      4'h1:    v = 17'd192;
      4'h2:    v = 17'd576;
      4'h3:    v = 17'd1152;
      4'h4:    v = 17'd2304;
      4'h5:    v = 17'd4608;
      4'h8:    v = 17'd256;
      4'h9:    v = 17'd512;
      4'hA:    v = 17'd1024;
      4'hB:    v = 17'd2048;
      4'hC:    v = 17'd4096;
      4'hD:    v = 17'd8192;
      4'hE:    v = 17'd16384;
      4'hF:    v = 17'd32768;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [RateW-1:0] rate_lookup(input logic [3:0] code);
    logic [RateW-1:0] v;
    case (code)
      4'h1:    v = 20'd88200;
      4'h2:    v = 20'd176400;
      4'h3:    v = 20'd192000;
      4'h4:    v = 20'd8000;
      4'h5:    v = 20'd16000;
      4'h6:    v = 20'd22050;
      4'h7:    v = 20'd24000;
      4'h8:    v = 20'd32000;
      4'h9:    v = 20'd44100;
      4'hA:    v = 20'd48000;
      4'hB:    v = 20'd96000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/fhc_rate_calc.sv]
// ----------------------------------------------------------------------------
// fhc_rate_calc: frame sample rate from rate code and extension
// Picks the stream rate, a table entry or the scaled extension value.
// ----------------------------------------------------------------------------
module fhc_rate_calc (
  input  logic [3:0]                 rate_code,
  input  logic [15:0]                ext_value,
  input  logic [fhc_pkg::RateW-1:0]  stream_rate,
  output logic [fhc_pkg::RateW-1:0]  rate
);
  import fhc_pkg::*;

  logic [25:0]      khz_prod;
  logic [RateW-1:0] dahz_prod;

  assign khz_prod  = {10'd0, ext_value} * {16'd0, KHZ_SCALE};
  assign dahz_prod = {4'd0, ext_value} * DAHZ_SCALE;

  always_comb begin
    case (rate_code) inside
      RATE_STREAM:                rate = stream_rate;
      [4'h1:RATE_TABLE_LAST]:     rate = rate_lookup(rate_code);
      RATE_KHZ:                   rate = khz_prod[RateW-1:0];
      RATE_HZ:                    rate = {4'd0, ext_value};
      RATE_DAHZ:                  rate = dahz_prod;
      default:                    rate = '0;
    endcase
  end

endmodule

[design/fhc_parser.sv]
// ----------------------------------------------------------------------------
// fhc_parser: header parse state and per-byte decode
// Holds the parse phase and running CRC; decodes one byte per fire.
// ----------------------------------------------------------------------------
module fhc_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic                       header_start,
  input  logic [7:0]                 data_byte,
  input  logic                       last_available,
  input  logic [fhc_pkg::RateW-1:0]  stream_rate,
  output fhc_pkg::result_t           result
);
  import fhc_pkg::*;

  phase_t           phase, phase_next, phase_eff;
  logic [7:0]       crc, crc_next, crc_eff;
  logic [3:0]       size_code, size_code_next, size_eff;
  logic [3:0]       rate_code, rate_code_next, rate_eff;
  logic [2:0]       cont_left, cont_left_next, cont_eff;
  logic [1:0]       ext_left, ext_left_next, ext_left_eff;
  logic [15:0]      ext_value, ext_value_next, ext_eff, ext_shift;
  logic [SizeW-1:0] dbs, dbs_next, dbs_eff;
  logic [RateW-1:0] final_rate;

  // Start byte wipes the header context before it is decoded
  assign phase_eff    = header_start ? PH_SYNC1 : phase;
  assign crc_eff      = header_start ? '0 : crc;
  assign size_eff     = header_start ? '0 : size_code;
  assign rate_eff     = header_start ? '0 : rate_code;
  assign cont_eff     = header_start ? '0 : cont_left;
  assign ext_left_eff = header_start ? '0 : ext_left;
  assign ext_eff      = header_start ? '0 : ext_value;
  assign dbs_eff      = header_start ? '0 : dbs;
  assign ext_shift    = {ext_eff[7:0], data_byte};

  fhc_rate_calc u_rate (
    .rate_code   (rate_eff),
    .ext_value   (ext_eff),
    .stream_rate (stream_rate),
    .rate        (final_rate)
  );

  always_comb begin
    phase_next     = phase;
    crc_next       = crc;
    size_code_next = size_code;
    rate_code_next = rate_code;
    cont_left_next = cont_left;
    ext_left_next  = ext_left;
    ext_value_next = ext_value;
    dbs_next       = dbs;
    result         = '0;

    if (fire && phase_eff != PH_IDLE) begin
      phase_next     = phase_eff;
      crc_next       = (phase_eff != PH_CRC) ? crc8_step(crc_eff, data_byte) : crc_eff;
      size_code_next = size_eff;
      rate_code_next = rate_eff;
      cont_left_next = cont_eff;
      ext_left_next  = ext_left_eff;
      ext_value_next = ext_eff;
      dbs_next       = dbs_eff;

      case (phase_eff)
        PH_SYNC1: begin
          if (data_byte != SYNC_BYTE0) begin
            result.valid  = 1'b1;
            result.status = ST_BAD_SYNC;
          end else begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if ((data_byte & SYNC1_MASK) != SYNC1_VALUE) begin
            result.valid  = 1'b1;
            result.status = ST_BAD_SYNC;
          end else begin
            phase_next = PH_CODES;
          end
        end
        PH_CODES: begin
          size_code_next = data_byte[7:4];
          rate_code_next = data_byte[3:0];
          if (data_byte[3:0] == RATE_BAD) begin
            result.valid  = 1'b1;
            result.status = ST_BAD_RATE;
          end else begin
            phase_next = PH_CHAN;
          end
        end
        PH_CHAN: begin
          phase_next = PH_NUM0;
        end
        PH_NUM0, PH_NUMC: begin
          logic num_bad;
          logic num_done;
          num_bad  = 1'b0;
          num_done = 1'b0;
          if (phase_eff == PH_NUM0) begin
            if (data_byte[7:6] == 2'b10 || data_byte[7:1] == 7'h7F) begin
              num_bad = 1'b1;
            end else begin
              // leading ones give the count of continuation bytes
              if (data_byte[7:2] == 6'h3F)      cont_left_next = 3'd5;
              else if (data_byte[7:3] == 5'h1F) cont_left_next = 3'd4;
              else if (data_byte[7:4] == 4'hF)  cont_left_next = 3'd3;
              else if (data_byte[7:5] == 3'h7)  cont_left_next = 3'd2;
              else if (data_byte[7:6] == 2'h3)  cont_left_next = 3'd1;
              else                              cont_left_next = 3'd0;
              if (cont_left_next != 3'd0) phase_next = PH_NUMC;
              else                        num_done = 1'b1;
            end
          end else begin
            if (data_byte[7:6] != 2'b10) begin
              num_bad = 1'b1;
            end else begin
              cont_left_next = cont_eff - 3'd1;
              num_done = (cont_eff == 3'd1);
            end
          end
          if (num_bad) begin
            result.valid  = 1'b1;
            result.status = ST_BAD_NUM;
          end
          if (num_done) begin
            ext_value_next = '0;
            if (size_eff == SIZE_EXT8) begin
              ext_left_next = 2'd1;
              phase_next    = PH_BSEXT;
            end else if (size_eff == SIZE_EXT16) begin
              ext_left_next = 2'd2;
              phase_next    = PH_BSEXT;
            end else begin
              dbs_next = size_lookup(size_eff);
              if (rate_eff == RATE_KHZ) begin
                ext_left_next = 2'd1;
                phase_next    = PH_SREXT;
              end else if (rate_eff == RATE_HZ || rate_eff == RATE_DAHZ) begin
                ext_left_next = 2'd2;
                phase_next    = PH_SREXT;
              end else begin
                ext_left_next = 2'd0;
                phase_next    = PH_CRC;
              end
            end
          end
        end
        PH_BSEXT: begin
          ext_value_next = ext_shift;
          ext_left_next  = ext_left_eff - 2'd1;
          if (ext_left_eff == 2'd1) begin
            dbs_next       = {1'b0, ext_shift} + 17'd1;
            ext_value_next = '0;
            if (rate_eff == RATE_KHZ) begin
              ext_left_next = 2'd1;
              phase_next    = PH_SREXT;
            end else if (rate_eff == RATE_HZ || rate_eff == RATE_DAHZ) begin
              ext_left_next = 2'd2;
              phase_next    = PH_SREXT;
            end else begin
              ext_left_next = 2'd0;
              phase_next    = PH_CRC;
            end
          end
        end
        PH_SREXT: begin
          ext_value_next = ext_shift;
          ext_left_next  = ext_left_eff - 2'd1;
          if (ext_left_eff == 2'd1) phase_next = PH_CRC;
        end
        PH_CRC: begin
          result.valid = 1'b1;
          if (data_byte == crc_eff) begin
            result.status        = ST_OK;
            result.frame_samples = dbs_eff;
            result.frame_rate    = final_rate;
          end else begin
            result.status = ST_CRC_ERR;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (!result.valid && last_available) begin
        result.valid  = 1'b1;
        result.status = ST_TRUNCATED;
      end
      if (result.valid) phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      crc       <= '0;
      size_code <= '0;
      rate_code <= '0;
      cont_left <= '0;
      ext_left  <= '0;
      ext_value <= '0;
      dbs       <= '0;
    end else begin
      phase     <= phase_next;
      crc       <= crc_next;
      size_code <= size_code_next;
      rate_code <= rate_code_next;
      cont_left <= cont_left_next;
      ext_left  <= ext_left_next;
      ext_value <= ext_value_next;
      dbs       <= dbs_next;
    end
  end

endmodule

[design/flac_frame_header_check.sv]
// ----------------------------------------------------------------------------
// flac_frame_header_check: byte-serial FLAC frame header parser and checker
// Input byte register, per-byte decode with CRC-8, registered result.
// ----------------------------------------------------------------------------
// Feed the header one byte per transfer, first byte (0xFF) flagged by
// header_start; a new header_start abandons any header in progress without a
// result. Every header that ends gives one result transfer: status, frame
// size in samples and frame rate (both zero unless status is OK). A byte is
// captured in the input register and decoded together with one CRC-8 step
// once the output register is free; its result then lands in the output
// register, so a transfer can be taken every cycle while in_stall is low, and
// a result is valid after the byte that ends the header has passed through
// the input register and the output register. in_stall only rises when a
// result sits in the output register under out_stall with a byte already
// waiting. The stream sample rate register (used for rate code 0) is always
// ready and must be written while no header is in progress.
module flac_frame_header_check (
  input  logic                       clk,
  input  logic                       rst,
  // byte input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       header_start,
  input  logic [7:0]                 data_byte,
  input  logic                       last_available,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output fhc_pkg::status_t           status,
  output logic [fhc_pkg::SizeW-1:0]  frame_samples,
  output logic [fhc_pkg::RateW-1:0]  frame_rate,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fhc_pkg::RateW-1:0]  stream_sample_rate
);
  import fhc_pkg::*;

  logic             stage_valid;
  logic             stage_start;
  logic [7:0]       stage_byte;
  logic             stage_last;
  logic             out_free;
  logic             fire;
  logic             in_take;
  logic [RateW-1:0] stream_rate;
  result_t          result;

  // Output register can take a new result when empty or draining this cycle
  assign out_free = !out_valid || !out_stall;
  assign fire     = stage_valid && out_free;
  assign in_stall = stage_valid && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_start <= header_start;
      stage_byte  <= data_byte;
      stage_last  <= last_available;
    end
  end

  // Stream rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_rate <= '0;
    end else if (cfg_valid && cfg_ready) begin
      stream_rate <= stream_sample_rate;
    end
  end

  fhc_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .header_start   (stage_start),
    .data_byte      (stage_byte),
    .last_available (stage_last),
    .stream_rate    (stream_rate),
    .result         (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && result.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.valid) begin
      status        <= result.status;
      frame_samples <= result.frame_samples;
      frame_rate    <= result.frame_rate;
    end
  end

  // A failed header never reports size or rate
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> frame_samples == '0 && frame_rate == '0)
    else $error("error result carries nonzero size or rate");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_TRUNCATED)
    else $error("result status out of range");

  // Back-pressure only comes from a held result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && stage_valid)
    else $error("input stalled without a held result");

  assert property (@(posedge clk) disable iff (rst)
    in_take |=> stage_valid)
    else $error("accepted byte lost from input register");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for flac_frame_header_check
// Feeds FLAC frame header bytes (clean, damaged, cut short and plain noise)
// with random gaps and output stalls. A byte-level tracker predicts the result
// of every header and each result transfer is checked field by field.
// ----------------------------------------------------------------------------

module tb_top;
  import fhc_pkg::*;

  // One expected header result
  typedef struct packed {
    status_t          st;
    logic [SizeW-1:0] bs;
    logic [RateW-1:0] sr;
  } hdr_result_t;

  // CRC-8, poly 0x07, shifted in MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Walks the header byte by byte like the parser does and queues the result
  // that each finished header should give.
  class frame_header_tracker;
    logic [RateW-1:0] stream_rate;
    hdr_result_t      due[$];
    int unsigned      fails;

    phase_t           ph;
    logic [7:0]       crc;
    logic [3:0]       size_code;
    logic [3:0]       rate_code;
    logic [2:0]       cont_left;
    logic [1:0]       ext_left;
    logic [15:0]      ext_val;
    logic [SizeW-1:0] blk_size;
    int unsigned      size_tab[16];
    int unsigned      rate_tab[12];

    function new();
      stream_rate = '0;
      fails       = 0;
      ph          = PH_IDLE;
      crc         = '0;
      size_code   = '0;
      rate_code   = '0;
      cont_left   = '0;
      ext_left    = '0;
      ext_val     = '0;
      blk_size    = '0;
      size_tab = '{0, 192, 576, 1152, 2304, 4608, 0, 0,
                   256, 512, 1024, 2048, 4096, 8192, 16384, 32768};
      rate_tab = '{0, 88200, 176400, 192000, 8000, 16000, 22050, 24000,
                   32000, 44100, 48000, 96000};
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void start_rate_ext();
      ext_val  = '0;
      ext_left = 2'd0;
      ph       = PH_CRC;
      if (rate_code == RATE_KHZ) begin
        ext_left = 2'd1;
        ph       = PH_SREXT;
      end else if (rate_code == RATE_HZ || rate_code == RATE_DAHZ) begin
        ext_left = 2'd2;
        ph       = PH_SREXT;
      end
    endfunction

    function void close_number();
      ext_val = '0;
      if (size_code == SIZE_EXT8) begin
        ext_left = 2'd1;
        ph       = PH_BSEXT;
      end else if (size_code == SIZE_EXT16) begin
        ext_left = 2'd2;
        ph       = PH_BSEXT;
      end else begin
        blk_size = SizeW'(size_tab[size_code]);
        start_rate_ext();
      end
    endfunction

    // Returns 0 when the byte is dropped by an idle parser
    function bit take_byte(input bit hs, input logic [7:0] b, input bit last);
      hdr_result_t r;
      bit          fin;
      int unsigned wide;
      r   = '0;
      fin = 1'b0;
      if (hs) begin
        ph        = PH_SYNC1;
        crc       = '0;
        size_code = '0;
        rate_code = '0;
        cont_left = '0;
        ext_left  = '0;
        ext_val   = '0;
        blk_size  = '0;
      end
      if (ph == PH_IDLE) return 1'b0;
      if (ph != PH_CRC) crc = crc8_next(crc, b);

      case (ph)
        PH_SYNC1: begin
          if (b != SYNC_BYTE0) begin
            r.st = ST_BAD_SYNC;
            fin  = 1'b1;
          end else ph = PH_SYNC2;
        end
        PH_SYNC2: begin
          if ((b & SYNC1_MASK) != SYNC1_VALUE) begin
            r.st = ST_BAD_SYNC;
            fin  = 1'b1;
          end else ph = PH_CODES;
        end
        PH_CODES: begin
          size_code = b[7:4];
          rate_code = b[3:0];
          if (rate_code == RATE_BAD) begin
            r.st = ST_BAD_RATE;
            fin  = 1'b1;
          end else ph = PH_CHAN;
        end
        PH_CHAN: ph = PH_NUM0;
        PH_NUM0: begin
          if (b[7:6] == 2'b10 || b >= 8'hFE) begin
            r.st = ST_BAD_NUM;
            fin  = 1'b1;
          end else begin
            if (b >= 8'hFC)      cont_left = 3'd5;
            else if (b >= 8'hF8) cont_left = 3'd4;
            else if (b >= 8'hF0) cont_left = 3'd3;
            else if (b >= 8'hE0) cont_left = 3'd2;
            else if (b >= 8'hC0) cont_left = 3'd1;
            else                 cont_left = 3'd0;
            if (cont_left != 3'd0) ph = PH_NUMC;
            else close_number();
          end
        end
        PH_NUMC: begin
          if (b[7:6] != 2'b10) begin
            r.st = ST_BAD_NUM;
            fin  = 1'b1;
          end else begin
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0) close_number();
          end
        end
        PH_BSEXT: begin
          ext_val  = {ext_val[7:0], b};
          ext_left = ext_left - 2'd1;
          if (ext_left == 2'd0) begin
            blk_size = SizeW'(ext_val) + SizeW'(1);
            start_rate_ext();
          end
        end
        PH_SREXT: begin
          ext_val  = {ext_val[7:0], b};
          ext_left = ext_left - 2'd1;
          if (ext_left == 2'd0) ph = PH_CRC;
        end
        PH_CRC: begin
          fin = 1'b1;
          if (b == crc) begin
            r.st = ST_OK;
            r.bs = blk_size;
            case (rate_code)
              RATE_STREAM: r.sr = stream_rate;
              RATE_KHZ: begin
                wide = ext_val * KHZ_SCALE;
                r.sr = wide[RateW-1:0];
              end
              RATE_HZ: r.sr = RateW'(ext_val);
              RATE_DAHZ: begin
                wide = ext_val * DAHZ_SCALE;
                r.sr = wide[RateW-1:0];
              end
              default: r.sr = (rate_code <= RATE_TABLE_LAST) ?
                              RateW'(rate_tab[rate_code]) : '0;
            endcase
          end else r.st = ST_CRC_ERR;
        end
        default: ;
      endcase

      if (!fin && last) begin
        r.st = ST_TRUNCATED;
        fin  = 1'b1;
      end
      if (fin) begin
        due.push_back(r);
        ph = PH_IDLE;
      end
      return 1'b1;
    endfunction

    function void match_result(input status_t st, input logic [SizeW-1:0] bs,
                               input logic [RateW-1:0] sr);
      hdr_result_t w;
      if (due.size() == 0) begin
        fails++;
        $display("%0t: result with nothing pending: status %0d frame_samples %0d frame_rate %0d",
                 $time, st, bs, sr);
        return;
      end
      w = due.pop_front();
      if (st !== w.st) begin
        fails++;
        $display("%0t: status expected %0d, got %0d", $time, w.st, st);
      end
      if (bs !== w.bs) begin
        fails++;
        $display("%0t: frame_samples expected %0d, got %0d", $time, w.bs, bs);
      end
      if (sr !== w.sr) begin
        fails++;
        $display("%0t: frame_rate expected %0d, got %0d", $time, w.sr, sr);
      end
    endfunction
  endclass

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off.
  localparam int IdleLimit = 4000;
  // Byte offset of the coded frame number inside a header
  localparam int NumAt     = 4;
  // Bytes per random phase (four phases)
  localparam int PhaseBytes = 390;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             header_start;
  logic [7:0]       data_byte;
  logic             last_available;
  logic             out_valid;
  logic             out_stall;
  status_t          status;
  logic [SizeW-1:0] frame_samples;
  logic [RateW-1:0] frame_rate;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [RateW-1:0] stream_sample_rate;

  frame_header_tracker hdr_trk = new();

  logic [7:0] hdr_bytes[$];   // header being built for the next send
  int         num_len;        // continuation bytes in its coded number
  bit         no_gaps;        // sender runs back to back for this header
  bit         hold_req;       // asks the result side for a long hold-off
  int         useful_bytes;   // bytes the parser actually consumed

  flac_frame_header_check i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .header_start       (header_start),
    .data_byte          (data_byte),
    .last_available     (last_available),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .frame_samples      (frame_samples),
    .frame_rate         (frame_rate),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .stream_sample_rate (stream_sample_rate)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // CRC over everything built so far in hdr_bytes
  function automatic logic [7:0] hdr_crc();
    logic [7:0] c;
    c = '0;
    foreach (hdr_bytes[i]) c = crc8_next(c, hdr_bytes[i]);
    return c;
  endfunction

  // Well-formed header with random codes, coded number length and extensions
  function automatic void make_header();
    logic [3:0] sc;
    logic [3:0] rc;
    logic [7:0] lead;
    sc      = 4'($urandom);
    rc      = 4'($urandom_range(0, 14));
    num_len = $urandom_range(0, 5);
    case (num_len)
      0:       lead = 8'($urandom_range(8'h00, 8'h7F));
      1:       lead = 8'($urandom_range(8'hC0, 8'hDF));
      2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
      3:       lead = 8'($urandom_range(8'hF0, 8'hF7));
      4:       lead = 8'($urandom_range(8'hF8, 8'hFB));
      default: lead = 8'($urandom_range(8'hFC, 8'hFD));
    endcase
    hdr_bytes.delete();
    hdr_bytes.push_back(SYNC_BYTE0);
    hdr_bytes.push_back(SYNC1_VALUE | 8'($urandom_range(0, 3)));
    hdr_bytes.push_back({sc, rc});
    hdr_bytes.push_back(8'($urandom));          // channels / bit depth: don't care
    hdr_bytes.push_back(lead);
    repeat (num_len) hdr_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    if (sc == SIZE_EXT8 || sc == SIZE_EXT16) hdr_bytes.push_back(8'($urandom));
    if (sc == SIZE_EXT16) hdr_bytes.push_back(8'($urandom));
    if (rc == RATE_KHZ || rc == RATE_HZ || rc == RATE_DAHZ) hdr_bytes.push_back(8'($urandom));
    if (rc == RATE_HZ || rc == RATE_DAHZ) hdr_bytes.push_back(8'($urandom));
    hdr_bytes.push_back(hdr_crc());
  endfunction

  // One byte transfer, preceded by a random gap unless the header runs
  // back to back. Valid stays up after the transfer; whoever idles next
  // lowers it.
  task automatic send_byte(input bit hs, input logic [7:0] b, input bit last);
    int gap;
    int r;
    gap = 0;
    if (!no_gaps) begin
      r = $urandom_range(0, 99);
      if (r < 65)      gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 12);
      else             gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    header_start   <= hs;
    data_byte      <= b;
    last_available <= last;
    do @(posedge clk); while (in_stall);
    if (hdr_trk.take_byte(hs, b, last)) useful_bytes++;
  endtask

  // Sends hdr_bytes[0 .. stop_at-1]; last_available on byte last_at (-1: never)
  task automatic send_header(input int last_at, input int stop_at);
    for (int i = 0; i < stop_at; i++)
      send_byte(i == 0, hdr_bytes[i], i == last_at);
  endtask

  // Sender stops and waits for every predicted result to come out.
  // Always waits on the clock before checking, so valid is not lowered and raised
  // in the same step.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (hdr_trk.pending() != 0);
  endtask

  task automatic write_stream_rate(input logic [RateW-1:0] v);
    cfg_valid          <= 1'b1;
    stream_sample_rate <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_trk.stream_rate = v;
  endtask

  // Phase boundary: a lone bad sync byte forces the parser idle, then wait
  // for all results and for bytes that give no result to drain, then
  // change the stream rate.
  task automatic quiesce_and_set_rate(input logic [RateW-1:0] v);
    send_byte(1'b1, 8'h00, 1'b0);
    wait_results();
    repeat (8) @(posedge clk);
    write_stream_rate(v);
  endtask

  // Mostly clean headers with random content; the rest damaged, cut short,
  // abandoned halfway or plain noise.
  task automatic run_random_headers(input int target);
    int start;
    int hdrs;
    int hold_at;
    int pick;
    int k;
    int idx;
    logic [1:0] top;
    start   = useful_bytes;
    hdrs    = 0;
    hold_at = $urandom_range(5, 20);
    while (useful_bytes - start < target) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      // long receiver hold-off while we keep pushing bytes: fills the block
      if (hdrs == hold_at) hold_req = 1'b1;
      // now and then stop sending until everything has come back
      if (hdrs % 40 == 39) wait_results();
      make_header();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_header(-1, hdr_bytes.size());
      end else if (pick < 68) begin
        // CRC mismatch
        hdr_bytes[hdr_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
        send_header($urandom_range(0, 1) ? hdr_bytes.size() - 1 : -1, hdr_bytes.size());
      end else if (pick < 75) begin
        // buffer runs dry before the CRC byte
        send_header($urandom_range(0, hdr_bytes.size() - 2), hdr_bytes.size());
      end else if (pick < 80) begin
        // one byte anywhere replaced
        idx = $urandom_range(0, hdr_bytes.size() - 1);
        hdr_bytes[idx] = 8'($urandom);
        send_header(-1, hdr_bytes.size());
      end else if (pick < 85) begin
        // reserved rate code
        hdr_bytes[2] = hdr_bytes[2] | {4'h0, RATE_BAD};
        send_header(-1, hdr_bytes.size());
      end else if (pick < 90) begin
        // abandoned: the next header_start restarts the parser
        send_header(-1, $urandom_range(1, hdr_bytes.size() - 1));
      end else if (pick < 95) begin
        // noise, mostly dropped by an idle parser
        k = $urandom_range(1, 6);
        repeat (k) send_byte($urandom_range(0, 9) == 0, 8'($urandom),
                             $urandom_range(0, 3) == 0);
      end else begin
        // broken coded number: bad lead byte or bad continuation
        if (num_len == 0 || $urandom_range(0, 1) == 0) begin
          hdr_bytes[NumAt] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hFE, 8'hFF));
        end else begin
          k   = $urandom_range(0, 2);
          top = (k == 2) ? 2'b11 : 2'(k);
          hdr_bytes[NumAt + 1 + $urandom_range(0, num_len - 1)] = {top, 6'($urandom)};
        end
        send_header(-1, hdr_bytes.size());
      end
      hdrs++;
    end
  endtask

  // Result side: checks every result transfer and drives out_stall in random
  // runs (short stalls, long stalls, stall-free stretches, and the long
  // hold-off on request).
  initial begin : result_side
    int run_left;
    int r;
    bit stall_val;
    out_stall = 1'b0;
    run_left  = 0;
    stall_val = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) hdr_trk.match_result(status, frame_samples, frame_rate);
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_val = 1'b1;
        run_left  = $urandom_range(250, 350);
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          stall_val = 1'b0;
          run_left  = $urandom_range(50, 120);
        end else if (r < 50) begin
          stall_val = 1'b0;
          run_left  = $urandom_range(0, 6);
        end else if (r < 85) begin
          stall_val = 1'b1;
          run_left  = $urandom_range(0, 2);
        end else if (r < 97) begin
          stall_val = 1'b1;
          run_left  = $urandom_range(3, 10);
        end else begin
          stall_val = 1'b1;
          run_left  = $urandom_range(20, 40);
        end
      end
      out_stall <= stall_val;
    end
  end

  // Watchdog: too long without any transfer means the block is stuck
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IdleLimit) begin
        $display("[flac_frame_header_check] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst                = 1'b1;
    in_valid           = 1'b0;
    header_start       = 1'b0;
    data_byte          = '0;
    last_available     = 1'b0;
    cfg_valid          = 1'b0;
    stream_sample_rate = '0;
    no_gaps            = 1'b0;
    hold_req           = 1'b0;
    useful_bytes       = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_stream_rate({RateW{1'b1}});

    // --- directed ---
    // stray byte while idle: dropped
    send_byte(1'b0, 8'h55, 1'b0);
    // header abandoned after two bytes, restart hits the reserved rate code
    send_byte(1'b1, 8'hFF, 1'b0);
    send_byte(1'b0, 8'hF8, 1'b0);
    send_byte(1'b1, 8'hFF, 1'b0);
    send_byte(1'b0, 8'hFB, 1'b0);
    send_byte(1'b0, {4'h2, RATE_BAD}, 1'b0);
    // bad first sync byte
    send_byte(1'b1, 8'h00, 1'b0);
    // lead byte 0xFE is not a valid coded number
    send_byte(1'b1, 8'hFF, 1'b0);
    send_byte(1'b0, 8'hF8, 1'b0);
    send_byte(1'b0, 8'h10, 1'b0);
    send_byte(1'b0, 8'h00, 1'b0);
    send_byte(1'b0, 8'hFE, 1'b0);
    // truncated on the first byte
    send_byte(1'b1, 8'hFF, 1'b1);
    // largest header: 16-bit size ext 0xFFFF (65536), 5 continuations,
    // rate 0xFFFF x10; last_available on the CRC byte must not matter
    hdr_bytes = '{8'hFF, 8'hF9, {SIZE_EXT16, RATE_DAHZ}, 8'hFF, 8'hFD,
                  8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    hdr_bytes.push_back(hdr_crc());
    send_header(hdr_bytes.size() - 1, hdr_bytes.size());
    // short header with a corrupted CRC
    hdr_bytes = '{8'hFF, 8'hF8, 8'hC9, 8'h00, 8'h00};
    hdr_bytes.push_back(hdr_crc() ^ 8'h80);
    send_header(-1, hdr_bytes.size());

    // --- random phases, stream rate at both extremes and in between ---
    quiesce_and_set_rate('0);
    run_random_headers(PhaseBytes);
    quiesce_and_set_rate({RateW{1'b1}});
    run_random_headers(PhaseBytes);
    quiesce_and_set_rate(RateW'($urandom_range(1, 1048574)));
    run_random_headers(PhaseBytes);
    quiesce_and_set_rate(RateW'(48000));
    run_random_headers(PhaseBytes);

    wait_results();
    repeat (10) @(posedge clk);
    if (hdr_trk.fails == 0 && hdr_trk.pending() == 0)
      $display("[flac_frame_header_check] OK");
    else
      $display("[flac_frame_header_check] ERROR");
    $finish;
  end

endmodule
